FILE: rtl/sd7seg_pkg.sv
// Shared types, constants and the digit glyph table for the seven-segment converter.
package sd7seg_pkg;

	localparam int unsigned SLOT_COUNT = 8;
	localparam int unsigned MAG_W      = 32;
	localparam int unsigned CNT_W      = 5;
	localparam int unsigned BCD_W      = 4 * SLOT_COUNT;
	localparam int unsigned GLYPH_W    = 7;
	localparam int unsigned SEG_W      = 8;
	localparam int unsigned NDIG_W     = 4;
	localparam int unsigned SHIFT_W    = 3;

	localparam logic [MAG_W-1:0]   MAX_POS     = 32'd99999999;
	localparam logic [MAG_W-1:0]   MAX_NEG_MAG = 32'd9999999;
	localparam logic [MAG_W-1:0]   MOST_NEG    = 32'h8000_0000;
	localparam logic [GLYPH_W-1:0] MINUS_GLYPH = 7'h40;
	localparam logic [GLYPH_W-1:0] BLANK_GLYPH = 7'h00;

	typedef logic [GLYPH_W-1:0] glyph_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_PLACE,
		ST_ALIGN
	} state_t;

	function automatic glyph_t digit_glyph(input logic [3:0] d);
		glyph_t g;
		unique case (d)
			4'd0:    g = 7'h3f;
			4'd1:    g = 7'h06;
			4'd2:    g = 7'h5b;
			4'd3:    g = 7'h4f;
			4'd4:    g = 7'h66;
			4'd5:    g = 7'h6d;
			4'd6:    g = 7'h7d;
			4'd7:    g = 7'h07;
			4'd8:    g = 7'h7f;
			4'd9:    g = 7'h6f;
			default: g = BLANK_GLYPH;
		endcase
		return g;
	endfunction

endpackage

FILE: rtl/signed_decimal_to_seven_segment_core.sv
// Signed 32-bit value to eight seven-segment slot patterns, bit-serial BCD conversion.
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------------
//  input   | in_valid / in_ready | value (32, signed), left_align (1)
//  output  | out_valid/out_ready | slot0_segments .. slot7_segments (8 each)
//
// Each item is converted by shift-add-3, one bit per cycle, then the digits are
// placed right-aligned, then shifted left one slot per step when left alignment
// is asked for; the result is then loaded into the output register.
// in_ready is high only while no conversion runs; the output register lets the
// next item enter while a result waits. A stalled output holds the last shift.
// Reset clears the state machine and the output valid flag only.
module signed_decimal_to_seven_segment_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] value,
	input  logic               left_align,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         slot0_segments,
	output logic [7:0]         slot1_segments,
	output logic [7:0]         slot2_segments,
	output logic [7:0]         slot3_segments,
	output logic [7:0]         slot4_segments,
	output logic [7:0]         slot5_segments,
	output logic [7:0]         slot6_segments,
	output logic [7:0]         slot7_segments
);

	localparam int unsigned N = sd7seg_pkg::SLOT_COUNT;

	sd7seg_pkg::state_t state_q, state_d;

	logic [sd7seg_pkg::MAG_W-1:0]   mag_q;
	logic [sd7seg_pkg::BCD_W-1:0]   bcd_q;
	logic [sd7seg_pkg::CNT_W-1:0]   cnt_q;
	logic                           neg_q, left_q, ovf_q;
	logic [sd7seg_pkg::SHIFT_W-1:0] shift_q;
	sd7seg_pkg::glyph_t             work_q [N];
	sd7seg_pkg::glyph_t             out_q  [N];
	logic                           out_valid_q;

	logic                           in_fire, out_free, load_out;
	logic                           in_neg, in_ovf;
	logic [sd7seg_pkg::MAG_W-1:0]   in_mag;
	logic [sd7seg_pkg::BCD_W-1:0]   bcd_adj;
	logic [sd7seg_pkg::NDIG_W-1:0]  ndig, total, gap;
	sd7seg_pkg::glyph_t             placed [N];

	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Magnitude and range check of the incoming item.
	always_comb begin
		in_neg = value[31];
		in_mag = in_neg ? (~value + 32'd1) : value;
		if (in_neg)
			in_ovf = (value == sd7seg_pkg::MOST_NEG) || (in_mag > sd7seg_pkg::MAX_NEG_MAG);
		else
			in_ovf = in_mag > sd7seg_pkg::MAX_POS;
	end

	// Add 3 to every BCD digit of five or more before the shift.
	always_comb begin
		for (int i = 0; i < N; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5)
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			else
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
		end
	end

	// Count significant digits and build the right-aligned text.
	always_comb begin
		ndig = 4'd1;
		for (int i = 1; i < N; i++) begin
			if (bcd_q[4*i +: 4] != 4'd0)
				ndig = sd7seg_pkg::NDIG_W'(i + 1);
		end
		total = ndig + {3'd0, neg_q};
		gap   = 4'd8 - total;
		for (int k = 0; k < N; k++) begin
			if (ovf_q)
				placed[k] = sd7seg_pkg::MINUS_GLYPH;
			else if (sd7seg_pkg::NDIG_W'(N - 1 - k) < ndig)
				placed[k] = sd7seg_pkg::digit_glyph(bcd_q[4*(N-1-k) +: 4]);
			else if (neg_q && sd7seg_pkg::NDIG_W'(N - 1 - k) == ndig)
				placed[k] = sd7seg_pkg::MINUS_GLYPH;
			else
				placed[k] = sd7seg_pkg::BLANK_GLYPH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= sd7seg_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			sd7seg_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid)
					state_d = sd7seg_pkg::ST_CONV;
			end
			sd7seg_pkg::ST_CONV: begin
				if (cnt_q == '0)
					state_d = sd7seg_pkg::ST_PLACE;
			end
			sd7seg_pkg::ST_PLACE: begin
				state_d = sd7seg_pkg::ST_ALIGN;
			end
			sd7seg_pkg::ST_ALIGN: begin
				if (shift_q == '0 && out_free) begin
					load_out = 1'b1;
					state_d  = sd7seg_pkg::ST_IDLE;
				end
			end
			default: state_d = sd7seg_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			mag_q  <= in_mag;
			bcd_q  <= '0;
			cnt_q  <= sd7seg_pkg::CNT_W'(sd7seg_pkg::MAG_W - 1);
			neg_q  <= in_neg;
			left_q <= left_align;
			ovf_q  <= in_ovf;
		end else if (state_q == sd7seg_pkg::ST_CONV) begin
			// Advance one magnitude bit into the BCD register.
			bcd_q <= {bcd_adj[sd7seg_pkg::BCD_W-2:0], mag_q[sd7seg_pkg::MAG_W-1]};
			mag_q <= {mag_q[sd7seg_pkg::MAG_W-2:0], 1'b0};
			cnt_q <= cnt_q - 1'b1;
		end

		if (state_q == sd7seg_pkg::ST_PLACE) begin
			work_q  <= placed;
			shift_q <= (left_q && !ovf_q) ? gap[sd7seg_pkg::SHIFT_W-1:0] : '0;
		end else if (state_q == sd7seg_pkg::ST_ALIGN && shift_q != '0) begin
			// Move the text one slot left, feed a blank at the right.
			for (int k = 0; k < N - 1; k++)
				work_q[k] <= work_q[k+1];
			work_q[N-1] <= sd7seg_pkg::BLANK_GLYPH;
			shift_q     <= shift_q - 1'b1;
		end

		if (load_out)
			out_q <= work_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_valid      = out_valid_q;
	assign slot0_segments = {1'b0, out_q[0]};
	assign slot1_segments = {1'b0, out_q[1]};
	assign slot2_segments = {1'b0, out_q[2]};
	assign slot3_segments = {1'b0, out_q[3]};
	assign slot4_segments = {1'b0, out_q[4]};
	assign slot5_segments = {1'b0, out_q[5]};
	assign slot6_segments = {1'b0, out_q[6]};
	assign slot7_segments = {1'b0, out_q[7]};

endmodule

FILE: rtl/sd7seg_checker.sv
// Port-level checks for the seven-segment converter, bound to the top level.
module sd7seg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  slot0_segments,
	input logic [7:0]  slot1_segments,
	input logic [7:0]  slot2_segments,
	input logic [7:0]  slot3_segments,
	input logic [7:0]  slot4_segments,
	input logic [7:0]  slot5_segments,
	input logic [7:0]  slot6_segments,
	input logic [7:0]  slot7_segments
);

	// A stalled result holds its slots.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(slot0_segments)
			&& $stable(slot1_segments) && $stable(slot2_segments)
			&& $stable(slot3_segments) && $stable(slot4_segments)
			&& $stable(slot5_segments) && $stable(slot6_segments)
			&& $stable(slot7_segments))
		else $error("output item changed while stalled");

	// One conversion at a time: busy right after an accept.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted during conversion");

	// Text always touches an end slot: slot 0 on left, slot 7 on right.
	a_text_anchored: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (slot0_segments != 8'h00) || (slot7_segments != 8'h00))
		else $error("text not anchored to an end slot");

	// Leftmost minus with a blank slot right after it cannot occur.
	a_minus_place: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && slot0_segments == {1'b0, sd7seg_pkg::MINUS_GLYPH}
			|-> slot1_segments != 8'h00)
		else $error("minus with no digit after it");

endmodule

bind signed_decimal_to_seven_segment_core sd7seg_checker u_sd7seg_checker (.*);

FILE: dv/seg_slot_checker.sv
// Checker: predicts the eight slot patterns for every accepted value and compares each result.
module seg_slot_checker
	import sd7seg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [31:0] value,
	input  logic               left_align,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [7:0]         slot0_segments,
	input  logic [7:0]         slot1_segments,
	input  logic [7:0]         slot2_segments,
	input  logic [7:0]         slot3_segments,
	input  logic [7:0]         slot4_segments,
	input  logic [7:0]         slot5_segments,
	input  logic [7:0]         slot6_segments,
	input  logic [7:0]         slot7_segments,
	output int unsigned        mismatch_count,
	output int unsigned        results_due
);

	typedef logic [SEG_W*SLOT_COUNT-1:0] slot_row_t;

	// common-cathode codes, digit 0 in the low bits
	localparam logic [10*GLYPH_W-1:0] DIGIT_SEGS = {
		7'h6f, 7'h7f, 7'h07, 7'h7d, 7'h6d, 7'h66, 7'h4f, 7'h5b, 7'h06, 7'h3f
	};

	slot_row_t expected_rows [$];
	slot_row_t seen_row;

	assign seen_row = {slot7_segments, slot6_segments, slot5_segments, slot4_segments,
		slot3_segments, slot2_segments, slot1_segments, slot0_segments};

	function automatic slot_row_t predict_slots(input logic [31:0] raw, input logic left);
		logic        negative;
		logic [31:0] mag;
		logic [3:0]  digit [SLOT_COUNT];
		int          n_digits;
		int          pos;
		int          k;
		slot_row_t   row;
		negative = raw[31];
		mag = negative ? (~raw + 32'd1) : raw;
		row = '0;
		if (negative ? (raw == MOST_NEG || mag > MAX_NEG_MAG) : (mag > MAX_POS))
			return {SLOT_COUNT{{1'b0, MINUS_GLYPH}}};
		// collect digits least significant first
		n_digits = 0;
		do begin
			digit[n_digits] = 4'(mag % 32'd10);
			mag = mag / 32'd10;
			n_digits++;
		end while (mag != 0 && n_digits < SLOT_COUNT);
		pos = left ? 0 : int'(SLOT_COUNT) - n_digits - (negative ? 1 : 0);
		if (negative) begin
			row[SEG_W*pos +: SEG_W] = {1'b0, MINUS_GLYPH};
			pos++;
		end
		for (k = n_digits - 1; k >= 0; k--) begin
			row[SEG_W*pos +: SEG_W] = {1'b0, DIGIT_SEGS[GLYPH_W*digit[k] +: GLYPH_W]};
			pos++;
		end
		return row;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		slot_row_t   want;
		int unsigned errs;
		int          k;
		if (!arst_n) begin
			expected_rows.delete();
			mismatch_count <= 0;
			results_due <= 0;
		end else begin
			errs = 0;
			if (in_valid && in_ready)
				expected_rows.push_back(predict_slots(value, left_align));
			if (out_valid && out_ready) begin
				if (expected_rows.size() == 0) begin
					$display("%0t: result with no item pending: expected none, actual %h",
						$time, seen_row);
					errs++;
				end else begin
					want = expected_rows.pop_front();
					for (k = 0; k < SLOT_COUNT; k++) begin
						if (want[SEG_W*k +: SEG_W] !== seen_row[SEG_W*k +: SEG_W]) begin
							$display("%0t: slot%0d_segments expected %h actual %h", $time, k,
								want[SEG_W*k +: SEG_W], seen_row[SEG_W*k +: SEG_W]);
							errs++;
						end
					end
				end
			end
			mismatch_count <= mismatch_count + errs;
			results_due <= expected_rows.size();
		end
	end

endmodule

FILE: dv/signed_decimal_to_seven_segment_core_tb.sv
// Testbench top: clock, reset, value stimulus with idling and stalls, watchdog and verdict.
module signed_decimal_to_seven_segment_core_tb;
	import sd7seg_pkg::*;

	localparam int unsigned LONG_HOLD   = 300;
	localparam int unsigned QUIET_LIMIT = 4000;
	localparam int unsigned SETTLE      = 60;
	localparam int unsigned PHASE_ITEMS = 250;

	logic               clk;
	logic               arst_n     = 1'b0;
	logic               in_valid   = 1'b0;
	logic               in_ready;
	logic signed [31:0] value      = '0;
	logic               left_align = 1'b0;
	logic               out_valid;
	logic               out_ready  = 1'b0;
	logic [7:0]         slot0_segments;
	logic [7:0]         slot1_segments;
	logic [7:0]         slot2_segments;
	logic [7:0]         slot3_segments;
	logic [7:0]         slot4_segments;
	logic [7:0]         slot5_segments;
	logic [7:0]         slot6_segments;
	logic [7:0]         slot7_segments;
	int unsigned        mismatch_count;
	int unsigned        results_due;

	int unsigned send_idle_pct    = 26;
	int unsigned recv_stall_pct   = 82;
	bit          hold_off_request = 1'b0;

	signed_decimal_to_seven_segment_core dut (.*);

	seg_slot_checker checker_inst (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Mostly well-formed numbers of random length and sign, some raw words, some edge values.
	function automatic logic [31:0] pick_value();
		int unsigned sel;
		int unsigned n_digits;
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] mag;
		sel = $urandom_range(99);
		if (sel < 70) begin
			n_digits = $urandom_range(8, 1);
			hi = 1;
			repeat (n_digits) hi = hi * 10;
			lo = (n_digits == 1) ? 32'd0 : hi / 10;
			mag = $urandom_range(hi - 1, lo);
			return $urandom_range(1) ? -mag : mag;
		end else if (sel < 85) begin
			return $urandom();
		end
		case ($urandom_range(5))
			0: mag = MAX_POS;
			1: mag = -MAX_NEG_MAG;
			2: mag = MOST_NEG;
			3: mag = 32'h7fff_ffff;
			4: mag = 32'd0;
			default: mag = 32'hffff_ffff;
		endcase
		return mag + $urandom_range(4) - 2;
	endfunction

	// Offer one item; drop valid only while idling so it is never lowered and raised in one step.
	task automatic send_item(input logic [31:0] v, input logic la);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		left_align <= la;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_random(input int unsigned count);
		repeat (count) send_item(pick_value(), 1'($urandom_range(1)));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (results_due != 0);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(0, 1'b1);
		send_item(0, 1'b0);
		send_item(1, 1'b1);
		send_item(-1, 1'b0);
		send_item(9, 1'b0);
		send_item(10, 1'b1);
		send_item(-10, 1'b1);
		send_item(12345678, 1'b1);
		send_item(-1234567, 1'b0);
		send_item(99999999, 1'b0);
		send_item(99999999, 1'b1);
		send_item(100000000, 1'b1);
		send_item(-9999999, 1'b1);
		send_item(-9999999, 1'b0);
		send_item(-10000000, 1'b0);
		send_item(32'h8000_0000, 1'b1);
		send_item(32'h7fff_ffff, 1'b0);
		send_item(32'hffff_ffff, 1'b1);
		send_item(-99999, 1'b1);
		send_item(1000000, 1'b0);
		send_item(88888888, 1'b0);
		send_random(PHASE_ITEMS - 21);
		drain_results();

		send_idle_pct = 82;
		recv_stall_pct = 26;
		send_random(PHASE_ITEMS);
		drain_results();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_random(20);
		// stall the output for a long stretch while items keep being offered
		hold_off_request = 1'b1;
		send_random(PHASE_ITEMS - 20);
		drain_results();

		repeat (SETTLE) @(posedge clk);
		if (mismatch_count == 0 && results_due == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		forever begin
			@(posedge clk);
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				repeat (LONG_HOLD) begin
					out_ready <= 1'b0;
					@(posedge clk);
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("tb: failure");
		$finish;
	end

endmodule
